### rtl/rne_pkg.sv
`default_nettype none
package rne_pkg;

	localparam int PROB_BITS        = 12;
	localparam int STATE_LOWER_BITS = 16;
	localparam int FREQ_FIELD_BITS  = 16;
	localparam int RENORM_BITS      = 16;

	localparam int STATE_W  = 32;
	localparam int WORD_W   = 32;
	localparam int PAIR_W   = 64;
	localparam int NUM_PAIRS = 8;
	localparam int NIB_W    = 4;
	localparam int BYTE_W   = 8;
	localparam int ADDR_W   = 6;
	localparam int PAIR_IDX_W = $clog2(NUM_PAIRS);
	localparam int ADDR_LSB = $clog2(PAIR_W / 8);

	// threshold = freq << THR_SHIFT, so x >= threshold iff (x >> THR_SHIFT) >= freq
	localparam int THR_SHIFT = STATE_LOWER_BITS - PROB_BITS + RENORM_BITS;

	localparam logic [STATE_W-1:0] LOWER_BOUND = STATE_W'(1) << STATE_LOWER_BITS;

	localparam int DIV_STEPS = STATE_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef logic [NUM_PAIRS-1:0][PAIR_W-1:0] table_t;

	typedef struct packed {
		logic accept;
		logic look;
		logic lo_nib;
		logic div_step;
		logic update;
		logic flush_out;
		logic out_hi;
		logic out_lo;
	} cmd_t;

	typedef struct packed {
		logic emit_hi;
		logic emit_lo;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

### rtl/rne_cfg_regs.sv
`default_nettype none
module rne_cfg_regs
	import rne_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [PAIR_W-1:0] pwdata,
	output logic      [PAIR_W-1:0] prdata,
	output logic                   pready,
	output table_t                 pairs
);

	logic [PAIR_IDX_W-1:0] idx;
	table_t                pairs_q;

	assign idx    = paddr[ADDR_W-1:ADDR_LSB];
	assign pready = 1'b1;
	assign prdata = pairs_q[idx];
	assign pairs  = pairs_q;

	// write the addressed table pair in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pairs_q <= '0;
		end else if (psel && penable && pwrite) begin
			pairs_q[idx] <= pwdata;
		end
	end

endmodule
`default_nettype wire

### rtl/rne_datapath.sv
`default_nettype none
module rne_datapath
	import rne_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output status_t                status,
	input  wire table_t            pairs,
	input  wire logic [BYTE_W-1:0] in_byte,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic      [WORD_W-1:0] out_word,
	output logic                   out_final,
	output logic                   out_last
);

	logic [STATE_W-1:0]         coder_state_q;
	logic [BYTE_W-1:0]          byte_q;
	logic [FREQ_FIELD_BITS-1:0] freq_q;
	logic [FREQ_FIELD_BITS-1:0] start_q;
	logic [STATE_W-1:0]         quo_q;
	logic [STATE_W-1:0]         rem_q;
	logic [RENORM_BITS-1:0]     word_hi_q;
	logic [RENORM_BITS-1:0]     word_lo_q;
	logic                       emit_hi_q;
	logic                       emit_lo_q;
	logic                       out_valid_q;
	logic [WORD_W-1:0]          out_word_q;
	logic                       out_final_q;
	logic                       out_last_q;

	logic [NIB_W-1:0]           nib;
	logic [PAIR_W-1:0]          pair;
	logic [WORD_W-1:0]          tword;
	logic [FREQ_FIELD_BITS-1:0] freq;
	logic [FREQ_FIELD_BITS-1:0] start;
	logic                       emit;
	logic [STATE_W-1:0]         x_div;
	logic [STATE_W:0]           trial;
	logic                       fits;
	logic [STATE_W-1:0]         new_state;
	logic                       out_load;

	// table lookup for the current nibble
	assign nib   = cmd.lo_nib ? byte_q[NIB_W-1:0] : byte_q[BYTE_W-1:NIB_W];
	assign pair  = pairs[nib[NIB_W-1:1]];
	assign tword = nib[0] ? pair[PAIR_W-1:WORD_W] : pair[WORD_W-1:0];
	assign freq  = tword[FREQ_FIELD_BITS-1:0];
	assign start = tword[2*FREQ_FIELD_BITS-1:FREQ_FIELD_BITS];

	// renormalize when the state has reached freq << THR_SHIFT
	assign emit  = (coder_state_q >> THR_SHIFT) >= STATE_W'(freq);
	assign x_div = emit ? (coder_state_q >> RENORM_BITS) : coder_state_q;

	// one restoring division step; a zero divisor yields all ones and rem = x
	assign trial = {rem_q, quo_q[STATE_W-1]};
	assign fits  = trial >= (STATE_W + 1)'(freq_q);

	assign new_state = (quo_q << PROB_BITS) + rem_q + STATE_W'(start_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coder_state_q <= LOWER_BOUND;
		end else if (cmd.update) begin
			coder_state_q <= new_state;
		end else if (cmd.flush_out) begin
			coder_state_q <= LOWER_BOUND;
		end
	end

	// hold the request byte, table fields, divider and emitted words
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_byte;
		end
		if (cmd.look) begin
			freq_q  <= freq;
			start_q <= start;
			quo_q   <= x_div;
			rem_q   <= '0;
			if (cmd.lo_nib) begin
				emit_lo_q <= emit;
				word_lo_q <= coder_state_q[RENORM_BITS-1:0];
			end else begin
				emit_hi_q <= emit;
				word_hi_q <= coder_state_q[RENORM_BITS-1:0];
			end
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[STATE_W-2:0], fits};
			rem_q <= fits ? STATE_W'(trial - (STATE_W + 1)'(freq_q)) : trial[STATE_W-1:0];
		end
	end

	// output register
	assign out_load = cmd.flush_out || cmd.out_hi || cmd.out_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush_out) begin
			out_word_q  <= coder_state_q;
			out_final_q <= 1'b1;
			out_last_q  <= 1'b1;
		end else if (cmd.out_hi) begin
			out_word_q  <= WORD_W'(word_hi_q);
			out_final_q <= 1'b0;
			out_last_q  <= !emit_lo_q;
		end else if (cmd.out_lo) begin
			out_word_q  <= WORD_W'(word_lo_q);
			out_final_q <= 1'b0;
			out_last_q  <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_final = out_final_q;
	assign out_last  = out_last_q;

	assign status.emit_hi  = emit_hi_q;
	assign status.emit_lo  = emit_lo_q;
	assign status.out_free = !out_valid_q || out_ready;

endmodule
`default_nettype wire

### rtl/rne_ctrl.sv
`default_nettype none
module rne_ctrl
	import rne_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_kind,
	output logic      in_ready,
	input  wire status_t status,
	output cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LOOK   = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_UPD    = 3'd3;
	localparam logic [2:0] ST_OUT_HI = 3'd4;
	localparam logic [2:0] ST_OUT_LO = 3'd5;
	localparam logic [2:0] ST_FLUSH  = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic             nib_lo_q;
	logic [CNT_W-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.lo_nib = nib_lo_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = in_kind ? ST_FLUSH : ST_LOOK;
				end
			end
			ST_LOOK: begin
				cmd.look = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				if (!nib_lo_q) begin
					state_d = ST_LOOK;
				end else if (status.emit_hi) begin
					state_d = ST_OUT_HI;
				end else if (status.emit_lo) begin
					state_d = ST_OUT_LO;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_OUT_HI: begin
				if (status.out_free) begin
					cmd.out_hi = 1'b1;
					state_d    = status.emit_lo ? ST_OUT_LO : ST_IDLE;
				end
			end
			ST_OUT_LO: begin
				if (status.out_free) begin
					cmd.out_lo = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_FLUSH: begin
				if (status.out_free) begin
					cmd.flush_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// advance state, nibble select and division step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nib_lo_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				nib_lo_q <= 1'b0;
			end else if (cmd.update) begin
				nib_lo_q <= 1'b1;
			end
			if (cmd.look) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

### rtl/rans_nibble_encoder_core.sv
`default_nettype none
// rANS encoder over 4-bit symbols with 16-bit renormalization. Feed source
// bytes last to first on the slave stream; each byte is coded upper nibble
// first. A request with tuser set flushes the 32-bit coder state as one
// result (tuser high) and returns the state to its lower bound. Encode
// requests give zero, one or two 16-bit words (tuser low), tlast on the last
// one. The symbol table lives in eight 64-bit APB registers at 8*i. One
// request is handled at a time: an encode request runs two table lookups,
// two 32-step restoring divisions on the shared radix-2 divider and two
// state updates, then output; a flush outputs the state. A result waits
// in the output register while the next request is taken. A zero
// frequency gives an unspecified code stream.
module rans_nibble_encoder_core
	import rne_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [PAIR_W-1:0] pwdata,
	output logic      [PAIR_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,  // [7:0] data_byte
	input  wire logic              s_axis_tuser,  // [0] kind
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic      [31:0]       m_axis_tdata,  // [31:0] out_word
	output logic                   m_axis_tuser,  // [0] is_final_state
	output logic                   m_axis_tlast
);

	table_t  pairs;
	cmd_t    cmd;
	status_t status;

	rne_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pairs   (pairs)
	);

	rne_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_kind  (s_axis_tuser),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rne_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pairs     (pairs),
		.in_byte   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_word  (m_axis_tdata),
		.out_final (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

endmodule
`default_nettype wire
